>>> src/drp_pkg.sv
// Shared types and constants for the Doppler ratio unit.
package drp_pkg;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CF,
        ST_DOT,
        ST_SQRT,
        ST_PJL,
        ST_PJS,
        ST_PREP1,
        ST_PREP2,
        ST_RATIO
    } t_state;

    localparam int SOUND_W = 20;
    localparam int TIME_W  = 16;
    localparam int CF_W    = SOUND_W + TIME_W;
    localparam int RATIO_W = 32;
    localparam logic [SOUND_W-1:0] SOUND_RESET = 20'd34300;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 32'h7FFF_FFFF;
    localparam logic [RATIO_W-1:0] RATIO_MIN   = 32'h8000_0000;

endpackage

>>> src/doppler_ratio_from_positions_unit.sv
// Doppler ratio from frame-to-frame source and listener positions.
// With no listener the result is registered directly; otherwise it is computed in turn by
// the bit-serial engine (WW = 74 at POS_WIDTH 32), with a shorter path when the
// separation is zero or the denominator is not positive.
// Throughput: one request at a time; the next is taken once the result has left.
// Reset (synchronous, active low) clears the stored positions, sets sound speed
// to 34300 cm/s and empties the output register.
module doppler_ratio_from_positions_unit #(
    parameter int POS_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [drp_pkg::SOUND_W-1:0]   i_cfg_sound_speed,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_listener_present,
    input  logic signed [31:0]            i_src_x,
    input  logic signed [31:0]            i_src_y,
    input  logic signed [31:0]            i_src_z,
    input  logic signed [31:0]            i_lis_x,
    input  logic signed [31:0]            i_lis_y,
    input  logic signed [31:0]            i_lis_z,
    input  logic [drp_pkg::TIME_W-1:0]    i_frame_time,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [drp_pkg::RATIO_W-1:0] o_ratio,
    output logic                          o_saturated
);
    import drp_pkg::*;

    localparam int PW   = POS_WIDTH;
    localparam int XW   = (PW > 32) ? PW : 32;
    localparam int DW   = PW + 1;
    localparam int DOTW = 2 * PW + 3;
    localparam int LW   = PW + 5;
    localparam int PJW  = PW + 8;
    localparam int NW   = (PW + 18 > 38) ? PW + 18 : 38;
    localparam int WA   = (2 * PW + 10 > NW + 16) ? 2 * PW + 10 : NW + 16;
    localparam int WW   = WA + (WA % 2);

    t_state r_state, n_state;
    logic   r_issued;
    logic [1:0] r_vec, r_k;
    logic   r_out_valid;
    logic [SOUND_W-1:0] r_sound;

    logic signed [PW-1:0]   r_prev_s [3];
    logic signed [PW-1:0]   r_prev_l [3];
    logic signed [DW-1:0]   r_d  [3];
    logic signed [DW-1:0]   r_dl [3];
    logic signed [DW-1:0]   r_ds [3];
    logic [TIME_W-1:0]      r_t;
    logic [CF_W-1:0]        r_cf;
    logic signed [DOTW-1:0] r_dotd, r_dotl, r_dots;
    logic [LW-1:0]          r_len;
    logic signed [PJW-1:0]  r_pl, r_ps;
    logic signed [NW-1:0]   r_nl, r_ns, r_num, r_den;
    logic [RATIO_W-1:0]     r_ratio;
    logic                   r_sat;

    logic                   w_in_acc;
    logic                   w_start;
    t_op                    w_op;
    logic [WW-1:0]          w_a, w_b;
    logic                   w_done;
    logic [WW-1:0]          w_res;
    logic signed [PW-1:0]   w_s [3];
    logic signed [PW-1:0]   w_l [3];
    logic [XW-1:0]          w_ext_s [3];
    logic [XW-1:0]          w_ext_l [3];
    logic signed [DW-1:0]   w_vk;
    logic signed [DW-1:0]   w_dk;
    logic [DW-1:0]          w_vk_mag, w_dk_mag;
    logic signed [DOTW-1:0] w_prod;
    logic signed [DOTW-1:0] w_dot_mag_l, w_dot_mag_s;
    logic signed [PJW-1:0]  w_pj;
    logic signed [NW-1:0]   w_len_s, w_sl, w_ss, w_num, w_den, w_num_mag;
    logic                   w_busy_st;

    drp_engine #(.WW(WW)) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_op     (w_op),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_done   (w_done),
        .o_result (w_res)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_ratio     = r_ratio;
    assign o_saturated = r_sat;

    always_comb begin
        w_ext_s[0] = XW'(unsigned'(i_src_x));
        w_ext_s[1] = XW'(unsigned'(i_src_y));
        w_ext_s[2] = XW'(unsigned'(i_src_z));
        w_ext_l[0] = XW'(unsigned'(i_lis_x));
        w_ext_l[1] = XW'(unsigned'(i_lis_y));
        w_ext_l[2] = XW'(unsigned'(i_lis_z));
        for (int i = 0; i < 3; i++) begin
            w_s[i] = signed'(w_ext_s[i][PW-1:0]);
            w_l[i] = signed'(w_ext_l[i][PW-1:0]);
        end
    end

    always_comb begin
        case (r_vec)
            2'd1:    w_vk = r_dl[r_k];
            2'd2:    w_vk = r_ds[r_k];
            default: w_vk = r_d[r_k];
        endcase
        w_dk        = r_d[r_k];
        w_vk_mag    = (w_vk < 0) ? DW'(-w_vk) : DW'(w_vk);
        w_dk_mag    = (w_dk < 0) ? DW'(-w_dk) : DW'(w_dk);
        w_prod      = ((w_vk < 0) != (w_dk < 0)) ? -DOTW'(w_res) : DOTW'(w_res);
        w_dot_mag_l = (r_dotl < 0) ? -r_dotl : r_dotl;
        w_dot_mag_s = (r_dots < 0) ? -r_dots : r_dots;
        w_pj        = signed'(PJW'(w_res));
        w_len_s     = signed'(NW'(r_len));
        w_sl        = w_len_s + NW'(r_pl);
        w_ss        = w_len_s + NW'(r_ps);
        w_num       = (r_nl <<< 8) + signed'(NW'(r_cf));
        w_den       = signed'(NW'(r_cf)) - (r_ns <<< 8);
        w_num_mag   = (r_num < 0) ? -r_num : r_num;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc && i_listener_present) n_state = ST_CF;
            ST_CF:    if (w_done) n_state = ST_DOT;
            ST_DOT:   if (w_done && r_vec == 2'd2 && r_k == 2'd2) n_state = ST_SQRT;
            ST_SQRT: begin
                if (w_done) n_state = (w_res == '0) ? ST_PREP1 : ST_PJL;
            end
            ST_PJL:   if (w_done) n_state = ST_PJS;
            ST_PJS:   if (w_done) n_state = ST_PREP1;
            ST_PREP1: n_state = ST_PREP2;
            ST_PREP2: n_state = (w_den > 0) ? ST_RATIO : ST_IDLE;
            ST_RATIO: if (w_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // engine requests
    always_comb begin
        w_op = OP_MUL;
        w_a  = '0;
        w_b  = '0;
        w_busy_st = 1'b1;
        unique case (r_state)
            ST_CF: begin
                w_a = WW'(r_sound);
                w_b = WW'(r_t);
            end
            ST_DOT: begin
                w_a = WW'(w_vk_mag);
                w_b = WW'(w_dk_mag);
            end
            ST_SQRT: begin
                w_op = OP_SQRT;
                w_a  = WW'(unsigned'(r_dotd)) << 8;
            end
            ST_PJL: begin
                w_op = OP_DIV;
                w_a  = WW'(unsigned'(w_dot_mag_l)) << 8;
                w_b  = WW'(r_len);
            end
            ST_PJS: begin
                w_op = OP_DIV;
                w_a  = WW'(unsigned'(w_dot_mag_s)) << 8;
                w_b  = WW'(r_len);
            end
            ST_RATIO: begin
                w_op = OP_DIV;
                w_a  = WW'(unsigned'(w_num_mag)) << 16;
                w_b  = WW'(unsigned'(r_den));
            end
            default: w_busy_st = 1'b0;
        endcase
        w_start = w_busy_st && !r_issued;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_vec       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_sound     <= SOUND_RESET;
            for (int i = 0; i < 3; i++) begin
                r_prev_s[i] <= '0;
                r_prev_l[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_issued <= 1'b1;
            end else if (w_done) begin
                r_issued <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_sound <= i_cfg_sound_speed;
            end
            if (w_in_acc && i_listener_present) begin
                r_vec <= '0;
                r_k   <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_prev_s[i] <= w_s[i];
                    r_prev_l[i] <= w_l[i];
                end
            end
            if (r_state == ST_DOT && w_done) begin
                if (r_k == 2'd2) begin
                    r_k   <= '0;
                    r_vec <= r_vec + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (i_out_ready && r_out_valid) begin
                r_out_valid <= 1'b0;
            end else if ((w_in_acc && !i_listener_present) ||
                         (r_state == ST_PREP2 && !(w_den > 0)) ||
                         (r_state == ST_RATIO && w_done)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (i_listener_present) begin
                for (int i = 0; i < 3; i++) begin
                    r_d[i]  <= DW'(w_s[i]) - DW'(w_l[i]);
                    r_dl[i] <= DW'(r_prev_l[i]) - DW'(w_l[i]);
                    r_ds[i] <= DW'(r_prev_s[i]) - DW'(w_s[i]);
                end
                r_t    <= (i_frame_time == '0) ? TIME_W'(1) : i_frame_time;
                r_dotd <= '0;
                r_dotl <= '0;
                r_dots <= '0;
            end else begin
                r_ratio <= '0;
                r_sat   <= 1'b0;
            end
        end
        unique case (r_state)
            ST_CF: if (w_done) r_cf <= w_res[CF_W-1:0];
            ST_DOT: begin
                if (w_done) begin
                    case (r_vec)
                        2'd1:    r_dotl <= r_dotl + w_prod;
                        2'd2:    r_dots <= r_dots + w_prod;
                        default: r_dotd <= r_dotd + w_prod;
                    endcase
                end
            end
            ST_SQRT: begin
                if (w_done) begin
                    r_len <= w_res[LW-1:0];
                    r_pl  <= '0;
                    r_ps  <= '0;
                end
            end
            ST_PJL: if (w_done) r_pl <= (r_dotl < 0) ? -w_pj : w_pj;
            ST_PJS: if (w_done) r_ps <= (r_dots < 0) ? -w_pj : w_pj;
            ST_PREP1: begin
                r_nl <= w_len_s - ((w_sl < 0) ? -w_sl : w_sl);
                r_ns <= ((w_ss < 0) ? -w_ss : w_ss) - w_len_s;
            end
            ST_PREP2: begin
                r_num <= w_num;
                r_den <= w_den;
                if (!(w_den > 0)) begin
                    r_ratio <= RATIO_MAX;
                    r_sat   <= 1'b1;
                end
            end
            ST_RATIO: begin
                if (w_done) begin
                    if (r_num < 0) begin
                        if ((|w_res[WW-1:32]) || (w_res[31] && (|w_res[30:0]))) begin
                            r_ratio <= RATIO_MIN;
                            r_sat   <= 1'b1;
                        end else begin
                            r_ratio <= -w_res[31:0];
                            r_sat   <= 1'b0;
                        end
                    end else if (|w_res[WW-1:31]) begin
                        r_ratio <= RATIO_MAX;
                        r_sat   <= 1'b1;
                    end else begin
                        r_ratio <= w_res[31:0];
                        r_sat   <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

>>> src/drp_engine.sv
// Shared bit-serial multiply, divide and square root unit.
module drp_engine #(
    parameter int WW = 74
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  drp_pkg::t_op    i_op,
    input  logic [WW-1:0]   i_a,
    input  logic [WW-1:0]   i_b,
    output logic            o_done,
    output logic [WW-1:0]   o_result
);
    import drp_pkg::*;

    localparam int CW = $clog2(WW);

    logic          r_busy;
    logic          r_done;
    t_op           r_op;
    logic [CW-1:0] r_cnt;
    logic [WW-1:0] r_x;
    logic [WW-1:0] r_y;
    logic [WW:0]   r_acc;
    logic [WW-1:0] r_q;

    logic [WW:0]   w_rem2;
    logic [WW:0]   w_cmp;
    logic [WW:0]   w_diff;
    logic          w_ge;
    logic [WW-1:0] w_sum;
    logic [CW-1:0] w_last;

    always_comb begin
        if (r_op == OP_SQRT) begin
            w_rem2 = {r_acc[WW-2:0], r_x[WW-1:WW-2]};
            w_cmp  = (WW+1)'({r_q, 2'b01});
        end else begin
            w_rem2 = {r_acc[WW-1:0], r_x[WW-1]};
            w_cmp  = {1'b0, r_y};
        end
        w_diff = w_rem2 - w_cmp;
        w_ge   = (w_rem2 >= w_cmp);
        w_sum  = r_acc[WW-1:0] + r_y;
        w_last = (r_op == OP_DIV) ? CW'(WW - 1) : CW'(WW / 2 - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_x   <= (i_op == OP_MUL) ? i_b : i_a;
            r_y   <= (i_op == OP_MUL) ? i_a : i_b;
            r_acc <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_x[0]) begin
                        r_acc <= {1'b0, w_sum};
                    end
                    r_x <= r_x >> 1;
                    r_y <= r_y << 1;
                end
                OP_SQRT: begin
                    r_acc <= w_ge ? w_diff : w_rem2;
                    r_q   <= {r_q[WW-2:0], w_ge};
                    r_x   <= r_x << 2;
                end
                default: begin
                    r_acc <= w_ge ? w_diff : w_rem2;
                    r_q   <= {r_q[WW-2:0], w_ge};
                    r_x   <= r_x << 1;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_MUL) ? r_acc[WW-1:0] : r_q;

endmodule
